// File: rtl/pcle_pkg.sv
// ============================================================================
// pcle_pkg: shared types and constants
// Operation codes, status codes, sequencer states and payload structs.
// ============================================================================
package pcle_pkg;

    localparam int unsigned DefCapacity   = 64;
    localparam int unsigned DefValueWidth = 32;
    localparam int unsigned PosWidth      = 7;
    localparam int unsigned LenWidth      = 7;
    localparam int unsigned FieldWidth    = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BEYOND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_WALK_WAIT,
        S_LINK_A,
        S_LINK_B,
        S_DEL_LINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]            operation;
        logic [PosWidth-1:0]   position;
        logic signed [FieldWidth-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [FieldWidth-1:0] read_value;
        logic [LenWidth-1:0]   list_length;
        logic [1:0]            status;
    } t_out_item;

endpackage

// File: rtl/pcle_node_mem.sv
// ============================================================================
// pcle_node_mem: node pool storage
// Separate value, next link and prev link memories, each with its own write
// port, sharing one read address, with registered read data.
// ============================================================================
module pcle_node_mem
    import pcle_pkg::*;
#(
    parameter int unsigned CAPACITY    = DefCapacity,
    parameter int unsigned VALUE_WIDTH = DefValueWidth,
    localparam int unsigned AW         = $clog2(CAPACITY)
) (
    input  logic                   i_clk,
    input  logic                   i_val_we,
    input  logic [AW-1:0]          i_val_addr,
    input  logic [VALUE_WIDTH-1:0] i_val_data,
    input  logic                   i_next_we,
    input  logic [AW-1:0]          i_next_addr,
    input  logic [AW-1:0]          i_next_data,
    input  logic                   i_prev_we,
    input  logic [AW-1:0]          i_prev_addr,
    input  logic [AW-1:0]          i_prev_data,
    input  logic [AW-1:0]          i_raddr,
    output logic [VALUE_WIDTH-1:0] o_val,
    output logic [AW-1:0]          o_next,
    output logic [AW-1:0]          o_prev
);

    logic [VALUE_WIDTH-1:0] r_val_mem  [CAPACITY];
    logic [AW-1:0]          r_next_mem [CAPACITY];
    logic [AW-1:0]          r_prev_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_rd_val;
    logic [AW-1:0]          r_rd_next;
    logic [AW-1:0]          r_rd_prev;

    always_ff @(posedge i_clk) begin
        if (i_val_we) begin
            r_val_mem[i_val_addr] <= i_val_data;
        end
        if (i_next_we) begin
            r_next_mem[i_next_addr] <= i_next_data;
        end
        if (i_prev_we) begin
            r_prev_mem[i_prev_addr] <= i_prev_data;
        end
        r_rd_val  <= r_val_mem[i_raddr];
        r_rd_next <= r_next_mem[i_raddr];
        r_rd_prev <= r_prev_mem[i_raddr];
    end

    assign o_val  = r_rd_val;
    assign o_next = r_rd_next;
    assign o_prev = r_rd_prev;

endmodule

// File: rtl/pcle_free_stack.sv
// ============================================================================
// pcle_free_stack: free slot stack
// Holds unused slot numbers. A written bit per entry makes an entry that was
// never pushed read as its own index, which matches the reset contents.
// ============================================================================
module pcle_free_stack
    import pcle_pkg::*;
#(
    parameter int unsigned CAPACITY = DefCapacity,
    localparam int unsigned AW      = $clog2(CAPACITY),
    localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop,
    input  logic          i_push,
    input  logic [AW-1:0] i_push_slot,
    output logic [AW-1:0] o_top_slot,
    output logic [CW-1:0] o_count
);

    logic [AW-1:0]       r_mem [CAPACITY];
    logic [CAPACITY-1:0] r_written;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [AW-1:0]       top_idx;
    logic [AW-1:0]       r_top;
    logic [AW-1:0]       r_top_idx;
    logic                r_top_written;
    logic                pop_ok;
    logic                push_ok;

    assign top_idx = AW'(r_count - CW'(1));
    assign pop_ok  = i_pop && (r_count != '0);
    assign push_ok = i_push && !i_pop && (r_count < CW'(CAPACITY));

    always_comb begin
        n_count = r_count;
        if (pop_ok) begin
            n_count = r_count - CW'(1);
        end else if (push_ok) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= CW'(CAPACITY);
            r_written <= '0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_written[AW'(r_count)] <= 1'b1;
            end
        end
    end

    // The top entry is read every cycle, so it is ready in the cycle after the
    // count settles.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[AW'(r_count)] <= i_push_slot;
        end
        r_top         <= r_mem[top_idx];
        r_top_written <= r_written[top_idx];
        r_top_idx     <= top_idx;
    end

    assign o_top_slot = r_top_written ? r_top : r_top_idx;
    assign o_count    = r_count;

endmodule

// File: rtl/positional_circular_list_engine.sv
// ============================================================================
// positional_circular_list_engine: circular doubly linked list sequencer
// Insert, delete and read at a one-based list position over a node pool.
// ============================================================================
// One item is in service at a time; o_in_stall is high from the cycle after
// acceptance until the result has been transferred. An error or
// no-operation goes from decode straight to the result, an insert at the
// head or tail goes straight to linking, and every other request first
// walks to its node. The position walk follows the next links from the
// head through the single registered read port of the node memory, one node
// per pass through the walk and wait states, and the result is held for as
// long as i_out_stall is high. The node memory has no reset; the free stack
// starts full with slot numbers in order and needs no clearing pass.
module positional_circular_list_engine
    import pcle_pkg::*;
#(
    parameter int unsigned CAPACITY    = DefCapacity,
    parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned VW   = VALUE_WIDTH;
    localparam int unsigned CmpW = (CW > PosWidth) ? CW : PosWidth;

    t_state r_state, n_state;

    // Captured request.
    t_op                 r_op;
    logic [PosWidth-1:0] r_pos;
    logic [VW-1:0]       r_val;

    // List registers and walk state. r_a and r_b are the neighbors that a
    // link update touches: the node before and the node after.
    logic [AW-1:0] r_head, r_tail, r_cur, r_new, r_a, r_b;
    logic [CW-1:0] r_len, r_steps;
    logic [VW-1:0] r_res_val;
    t_status       r_res_st;

    // Node memory ports.
    logic          val_we, next_we, prev_we;
    logic [AW-1:0] val_addr, next_addr, prev_addr, mem_raddr;
    logic [VW-1:0] val_wdata;
    logic [AW-1:0] next_wdata, prev_wdata;
    logic [VW-1:0] rd_val;
    logic [AW-1:0] rd_next, rd_prev;

    logic          fs_pop, fs_push;
    logic [AW-1:0] fs_top;
    logic [CW-1:0] fs_count;

    pcle_node_mem #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_mem (
        .i_clk      (i_clk),
        .i_val_we   (val_we),
        .i_val_addr (val_addr),
        .i_val_data (val_wdata),
        .i_next_we  (next_we),
        .i_next_addr(next_addr),
        .i_next_data(next_wdata),
        .i_prev_we  (prev_we),
        .i_prev_addr(prev_addr),
        .i_prev_data(prev_wdata),
        .i_raddr    (mem_raddr),
        .o_val      (rd_val),
        .o_next     (rd_next),
        .o_prev     (rd_prev)
    );

    pcle_free_stack #(.CAPACITY(CAPACITY)) u_free (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop      (fs_pop),
        .i_push     (fs_push),
        .i_push_slot(r_cur),
        .o_top_slot (fs_top),
        .o_count    (fs_count)
    );

    logic accept;
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Position compares against the current length, at a common width.
    logic [CmpW-1:0] pos_x, len_x;
    logic            pos_le1, pos_ge_len, pos_gt_len, ins_full, ins_at_end, len_is1;
    logic [CW-1:0]   ins_hops, mid_hops, rd_hops;

    assign pos_x      = CmpW'(r_pos);
    assign len_x      = CmpW'(r_len);
    assign pos_le1    = (r_pos <= PosWidth'(1));
    assign pos_ge_len = (pos_x >= len_x);
    assign pos_gt_len = (pos_x > len_x);
    assign ins_full   = (r_len >= CW'(CAPACITY)) || (fs_count == '0);
    assign ins_at_end = (r_len == '0) || pos_le1 || pos_ge_len;
    assign len_is1    = (r_len == CW'(1));

    // Hops from the head: to the node before the new one for a middle
    // insert, to the target node for a middle delete or a read.
    assign ins_hops = CW'(pos_x - CmpW'(2));
    assign mid_hops = CW'(pos_x - CmpW'(1));
    assign rd_hops  = (r_pos == '0) ? '0 : mid_hops;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_op)
                    OP_INSERT: begin
                        if (ins_full) n_state = S_DONE;
                        else if (ins_at_end) n_state = S_LINK_A;
                        else n_state = S_WALK;
                    end
                    OP_DELETE: begin
                        if (r_len == '0) n_state = S_DONE;
                        else n_state = S_WALK;
                    end
                    OP_READ: begin
                        if (r_len == '0 || pos_gt_len) n_state = S_DONE;
                        else n_state = S_WALK;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_WALK:      n_state = S_WALK_WAIT;
            S_WALK_WAIT: begin
                if (r_steps != '0) begin
                    n_state = S_WALK;
                end else begin
                    case (r_op)
                        OP_INSERT: n_state = S_LINK_A;
                        OP_DELETE: n_state = S_DEL_LINK;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_LINK_A:    n_state = S_LINK_B;
            S_LINK_B:    n_state = S_DONE;
            S_DEL_LINK:  n_state = S_DONE;
            S_DONE: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Memory and stack control. An insert writes the new node whole, then
    // points its two neighbors at it; a delete points the neighbors of the
    // removed node at each other and returns its slot.
    always_comb begin
        val_we     = 1'b0;
        next_we    = 1'b0;
        prev_we    = 1'b0;
        val_addr   = r_new;
        next_addr  = r_new;
        prev_addr  = r_new;
        val_wdata  = r_val;
        next_wdata = r_b;
        prev_wdata = r_a;
        mem_raddr  = r_cur;
        fs_pop     = 1'b0;
        fs_push    = 1'b0;
        case (r_state)
            S_DECODE: begin
                fs_pop = (r_op == OP_INSERT) && !ins_full;
            end
            S_LINK_A: begin
                val_we  = 1'b1;
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            S_LINK_B: begin
                next_we    = 1'b1;
                next_addr  = r_a;
                next_wdata = r_new;
                prev_we    = 1'b1;
                prev_addr  = r_b;
                prev_wdata = r_new;
            end
            S_DEL_LINK: begin
                fs_push = 1'b1;
                if (!len_is1) begin
                    next_we    = 1'b1;
                    next_addr  = r_a;
                    next_wdata = r_b;
                    prev_we    = 1'b1;
                    prev_addr  = r_b;
                    prev_wdata = r_a;
                end
            end
            default: ;
        endcase
    end

    // State, head, tail and length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_LINK_B: begin
                    r_len <= r_len + CW'(1);
                    if (r_len == '0) begin
                        r_head <= r_new;
                        r_tail <= r_new;
                    end else if (pos_le1) begin
                        r_head <= r_new;
                    end else if (pos_ge_len) begin
                        r_tail <= r_new;
                    end
                end
                S_DEL_LINK: begin
                    r_len <= r_len - CW'(1);
                    if (len_is1) begin
                        r_head <= '0;
                        r_tail <= '0;
                    end else begin
                        if (r_cur == r_head) r_head <= r_b;
                        if (r_cur == r_tail) r_tail <= r_a;
                    end
                end
                default: ;
            endcase
        end
    end

    // Request capture, walk and result registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= t_op'(i_in_data.operation);
            r_pos <= i_in_data.position;
            r_val <= VW'($unsigned(i_in_data.value));
        end
        case (r_state)
            S_DECODE: begin
                r_res_val <= '0;
                r_res_st  <= ST_OK;
                r_cur     <= r_head;
                r_steps   <= '0;
                r_new     <= fs_top;
                r_a       <= r_tail;
                r_b       <= r_head;
                case (r_op)
                    OP_INSERT: begin
                        if (ins_full) begin
                            r_res_st <= ST_FULL;
                        end else begin
                            r_res_val <= r_val;
                            // A lone node links to itself.
                            if (r_len == '0) begin
                                r_a <= fs_top;
                                r_b <= fs_top;
                            end else if (!ins_at_end) begin
                                r_steps <= ins_hops;
                            end
                        end
                    end
                    OP_DELETE: begin
                        if (r_len == '0) r_res_st <= ST_EMPTY;
                        else if (pos_le1) r_cur <= r_head;
                        else if (pos_ge_len) r_cur <= r_tail;
                        else r_steps <= mid_hops;
                    end
                    OP_READ: begin
                        if (r_len == '0) r_res_st <= ST_EMPTY;
                        else if (pos_gt_len) r_res_st <= ST_BEYOND;
                        else r_steps <= rd_hops;
                    end
                    default: ;
                endcase
            end
            S_WALK_WAIT: begin
                if (r_steps != '0) begin
                    r_steps <= r_steps - CW'(1);
                    r_cur   <= rd_next;
                end else begin
                    case (r_op)
                        OP_INSERT: begin
                            r_a <= r_cur;
                            r_b <= rd_next;
                        end
                        OP_DELETE: begin
                            r_res_val <= rd_val;
                            r_a       <= rd_prev;
                            r_b       <= rd_next;
                        end
                        default: r_res_val <= rd_val;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid            = (r_state == S_DONE);
    assign o_out_data.read_value  = FieldWidth'(r_res_val);
    assign o_out_data.list_length = LenWidth'(r_len);
    assign o_out_data.status      = r_res_st;

endmodule
